/* rtl/cgma_pkg.sv */
// ----------------------------------------------------------------------------
// cgma_pkg
// Shared sizes, codes and types of the class-grouped mean accumulator.
// ----------------------------------------------------------------------------
package cgma_pkg;

  localparam int MAX_CLASSES     = 256;
  localparam int FIELDS_PER_ITEM = 17;
  localparam int VALUE_BITS      = 48;
  localparam int COUNT_BITS      = 12;

  localparam int KIND_W   = 2;
  localparam int CLASS_W  = 8;
  localparam int FIELD_W  = 5;
  localparam int VALUE_W  = 48;
  localparam int MEAN_W   = 48;
  localparam int MCOUNT_W = 12;

  localparam int CELLS  = MAX_CLASSES * FIELDS_PER_ITEM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int SUM_W  = VALUE_BITS + COUNT_BITS;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACC   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_QRY,
    ST_DIV,
    ST_SIGN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [SUM_W-1:0]      sum;
    logic [COUNT_BITS-1:0] count;
    logic                  ovf;
  } cell_t;

  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

/* rtl/cgma_alu.sv */
// ----------------------------------------------------------------------------
// cgma_alu
// Shared add/subtract unit: accumulate, negate and every divider step.
// ----------------------------------------------------------------------------
module cgma_alu (
  input  cgma_pkg::alu_req_t             req_i,
  output logic [cgma_pkg::SUM_W-1:0]     y_o
);

  // one carry chain: invert b and carry in for subtract
  assign y_o = req_i.a + (req_i.b ^ {cgma_pkg::SUM_W{req_i.sub}})
             + cgma_pkg::SUM_W'(req_i.sub);

endmodule

/* rtl/cgma_ram.sv */
// ----------------------------------------------------------------------------
// cgma_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cgma_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/class_grouped_mean_accumulator.sv */
// ----------------------------------------------------------------------------
// class_grouped_mean_accumulator
// Per class and field running sums and counts, with truncated mean queries.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_stall_o is high while it is in work. An
// accumulate reads the cell, then read-modify-writes it in the cell RAM. A
// query of an empty or out-of-range cell skips the divider; any other query
// runs the divider on the one shared 60-bit adder, one quotient bit per
// cycle (60 steps, between the read and the sign and output load). After
// reset and after every clear item the cell RAM is swept to zero, one cell
// per cycle, over all 4352 cells before the next item is taken. A finished
// result waits in the output register, and the block goes on taking items
// behind it until a second result has to be loaded.
// ----------------------------------------------------------------------------
module class_grouped_mean_accumulator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [cgma_pkg::KIND_W-1:0]           kind_i,
  input  logic [cgma_pkg::CLASS_W-1:0]          class_id_i,
  input  logic [cgma_pkg::FIELD_W-1:0]          field_index_i,
  input  logic signed [cgma_pkg::VALUE_W-1:0]   value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cgma_pkg::MEAN_W-1:0]    mean_value_o,
  output logic [cgma_pkg::MCOUNT_W-1:0]         member_count_o,
  output logic                                  is_empty_o,
  output logic                                  saturated_o
);

  localparam int SUM_W  = cgma_pkg::SUM_W;
  localparam int ADDR_W = cgma_pkg::ADDR_W;
  localparam int CNT_W  = cgma_pkg::COUNT_BITS;
  localparam int VB     = cgma_pkg::VALUE_BITS;

  cgma_pkg::state_e state_q, state_d;

  logic [ADDR_W-1:0]               addr_q, addr_d;
  logic [VB-1:0]                   value_q, value_d;
  logic                            in_range_q, in_range_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic                            ovf_q, ovf_d;
  logic                            neg_q, neg_d;
  logic [CNT_W-1:0]                rem_q, rem_d;
  logic [SUM_W-1:0]                dvd_q, dvd_d;
  logic [cgma_pkg::STEP_W-1:0]     step_q, step_d;

  logic [cgma_pkg::MEAN_W-1:0]     res_mean_q, res_mean_d;
  logic [cgma_pkg::MCOUNT_W-1:0]   res_cnt_q, res_cnt_d;
  logic                            res_empty_q, res_empty_d;
  logic                            res_sat_q, res_sat_d;

  logic                            out_valid_q;
  logic                            out_load;

  logic                            in_accept;
  logic                            in_range;
  logic [ADDR_W-1:0]               in_index;

  logic                            ram_we;
  logic                            ram_re;
  cgma_pkg::cell_t                 ram_wdata;
  cgma_pkg::cell_t                 ram_rdata;

  cgma_pkg::alu_req_t              alu_req;
  logic [SUM_W-1:0]                alu_y;

  logic [CNT_W:0]                  div_shift;
  logic                            div_ge;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_range  = (int'(class_id_i) < cgma_pkg::MAX_CLASSES)
                  && (int'(field_index_i) < cgma_pkg::FIELDS_PER_ITEM);
  assign in_index  = ADDR_W'(class_id_i) * ADDR_W'(cgma_pkg::FIELDS_PER_ITEM)
                   + ADDR_W'(field_index_i);

  assign div_shift = {rem_q, dvd_q[SUM_W-1]};
  assign div_ge    = !alu_y[SUM_W-1];

  cgma_ram #(
    .DEPTH(cgma_pkg::CELLS),
    .WIDTH($bits(cgma_pkg::cell_t))
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(in_index),
    .rdata_o(ram_rdata)
  );

  cgma_alu u_alu (
    .req_i(alu_req),
    .y_o  (alu_y)
  );

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    value_d     = value_q;
    in_range_d  = in_range_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    neg_d       = neg_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    step_d      = step_q;
    res_mean_d  = res_mean_q;
    res_cnt_d   = res_cnt_q;
    res_empty_d = res_empty_q;
    res_sat_d   = res_sat_q;
    in_stall_o  = 1'b1;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = '0;
    alu_req     = '0;
    out_load    = 1'b0;

    unique case (state_q)
      cgma_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (addr_q == ADDR_W'(cgma_pkg::CELLS - 1)) begin
          state_d = cgma_pkg::ST_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      cgma_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ram_re     = 1'b1;
          addr_d     = in_index;
          value_d    = value_i[VB-1:0];
          in_range_d = in_range;
          unique case (kind_i)
            cgma_pkg::KIND_ACC: begin
              if (in_range) begin
                state_d = cgma_pkg::ST_ACC;
              end
            end
            cgma_pkg::KIND_QUERY: state_d = cgma_pkg::ST_QRY;
            cgma_pkg::KIND_CLEAR: begin
              addr_d  = '0;
              state_d = cgma_pkg::ST_CLEAR;
            end
            default: ;
          endcase
        end
      end

      cgma_pkg::ST_ACC: begin
        ram_we = 1'b1;
        if (ram_rdata.count == cgma_pkg::COUNT_MAX) begin
          ram_wdata     = ram_rdata;
          ram_wdata.ovf = 1'b1;
        end else begin
          alu_req.a       = ram_rdata.sum;
          alu_req.b       = {{(SUM_W - VB){value_q[VB-1]}}, value_q};
          ram_wdata.sum   = alu_y;
          ram_wdata.count = ram_rdata.count + 1'b1;
          ram_wdata.ovf   = ram_rdata.ovf;
        end
        state_d = cgma_pkg::ST_IDLE;
      end

      cgma_pkg::ST_QRY: begin
        if (!in_range_q || ram_rdata.count == '0) begin
          res_mean_d  = '0;
          res_cnt_d   = '0;
          res_empty_d = 1'b1;
          res_sat_d   = in_range_q && ram_rdata.ovf;
          state_d     = cgma_pkg::ST_DONE;
        end else begin
          // take the magnitude of the sum as dividend
          alu_req.b   = ram_rdata.sum;
          alu_req.sub = ram_rdata.sum[SUM_W-1];
          dvd_d       = alu_y;
          neg_d       = ram_rdata.sum[SUM_W-1];
          cnt_d       = ram_rdata.count;
          ovf_d       = ram_rdata.ovf;
          rem_d       = '0;
          step_d      = '0;
          state_d     = cgma_pkg::ST_DIV;
        end
      end

      cgma_pkg::ST_DIV: begin
        // restoring step: trial subtract of the count from the shifted remainder
        alu_req.a   = SUM_W'(div_shift);
        alu_req.b   = SUM_W'(cnt_q);
        alu_req.sub = 1'b1;
        rem_d       = div_ge ? alu_y[CNT_W-1:0] : div_shift[CNT_W-1:0];
        dvd_d       = {dvd_q[SUM_W-2:0], div_ge};
        if (step_q == cgma_pkg::STEP_W'(SUM_W - 1)) begin
          state_d = cgma_pkg::ST_SIGN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end

      cgma_pkg::ST_SIGN: begin
        alu_req.b   = dvd_q;
        alu_req.sub = neg_q;
        res_mean_d  = alu_y[cgma_pkg::MEAN_W-1:0];
        res_cnt_d   = cgma_pkg::MCOUNT_W'(cnt_q);
        res_empty_d = 1'b0;
        res_sat_d   = ovf_q;
        state_d     = cgma_pkg::ST_DONE;
      end

      cgma_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = cgma_pkg::ST_IDLE;
        end
      end

      default: state_d = cgma_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cgma_pkg::ST_CLEAR;
      addr_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      step_q  <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    in_range_q  <= in_range_d;
    cnt_q       <= cnt_d;
    ovf_q       <= ovf_d;
    neg_q       <= neg_d;
    rem_q       <= rem_d;
    dvd_q       <= dvd_d;
    res_mean_q  <= res_mean_d;
    res_cnt_q   <= res_cnt_d;
    res_empty_q <= res_empty_d;
    res_sat_q   <= res_sat_d;
    if (out_load) begin
      mean_value_o   <= res_mean_q;
      member_count_o <= res_cnt_q;
      is_empty_o     <= res_empty_q;
      saturated_o    <= res_sat_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // remainder stays below the divisor through every step
  a_rem_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cgma_pkg::ST_DIV |-> rem_q < cnt_q)
    else $error("divider remainder not below count");

  // quotient magnitude fits the mean field
  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cgma_pkg::ST_SIGN |-> dvd_q <= (SUM_W'(1) << (VB - 1)))
    else $error("quotient magnitude out of range");

  a_clear_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && kind_i == cgma_pkg::KIND_CLEAR
    |=> state_q == cgma_pkg::ST_CLEAR && addr_q == '0)
    else $error("clear item did not start sweep at cell zero");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> mean_value_o == '0 && member_count_o == '0)
    else $error("empty result with nonzero mean or count");

endmodule

/* tb/sv/class_grouped_mean_accumulator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// class_grouped_mean_accumulator_tb
// Self-checking bench for the class-grouped mean accumulator. A directed table
// covers empty, out-of-range and extreme cells, the reserved kind and the clear.
// Two cells are then filled to a full count to reach the dropped-add case.
// A random run then works a few busy cells with random stalls on both sides.
// Each query result is checked against its typed row or a cycle-free cell model.
// ----------------------------------------------------------------------------
module class_grouped_mean_accumulator_tb;

  localparam int KIND_W          = cgma_pkg::KIND_W;
  localparam int CLASS_W         = cgma_pkg::CLASS_W;
  localparam int FIELD_W         = cgma_pkg::FIELD_W;
  localparam int VALUE_W         = cgma_pkg::VALUE_W;
  localparam int MEAN_W          = cgma_pkg::MEAN_W;
  localparam int MCOUNT_W        = cgma_pkg::MCOUNT_W;
  localparam int SUM_W           = cgma_pkg::SUM_W;
  localparam int COUNT_BITS      = cgma_pkg::COUNT_BITS;
  localparam int CELLS           = cgma_pkg::CELLS;
  localparam int MAX_CLASSES     = cgma_pkg::MAX_CLASSES;
  localparam int FIELDS_PER_ITEM = cgma_pkg::FIELDS_PER_ITEM;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = cgma_pkg::COUNT_MAX;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOT_CELLS    = 6;
  localparam int DIR_ROWS     = 25;

  localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;

  localparam logic signed [VALUE_W-1:0] VAL_MAX  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN  = 48'sh8000_0000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_ZERO = 48'sd0;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [CLASS_W-1:0]         cls;
    logic [FIELD_W-1:0]         fld;
    logic signed [VALUE_W-1:0]  val;
  } cell_req_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [MCOUNT_W-1:0]      count;
    logic                     empty;
    logic                     sat;
  } mean_res_t;

  typedef struct packed {
    cell_req_t req;
    logic      typed;
    mean_res_t want;
  } dir_row_t;

  localparam mean_res_t EMPTY_RES  = '{mean: '0, count: '0, empty: 1'b1, sat: 1'b0};
  localparam mean_res_t MAX_OF_TWO = '{mean: VAL_MAX, count: 12'd2, empty: 1'b0, sat: 1'b0};
  localparam mean_res_t MIN_OF_ONE = '{mean: VAL_MIN, count: 12'd1, empty: 1'b0, sat: 1'b0};

  // Rows with typed 0 are checked against the cell model only.
  localparam dir_row_t DIR_STEPS [DIR_ROWS] = '{
    '{'{cgma_pkg::KIND_QUERY, 8'd0,   5'd0,  VAL_ZERO},            1'b1, EMPTY_RES},
    '{'{cgma_pkg::KIND_QUERY, 8'd255, 5'd16, VAL_ZERO},            1'b1, EMPTY_RES},
    '{'{cgma_pkg::KIND_QUERY, 8'd3,   5'd17, VAL_ZERO},            1'b1, EMPTY_RES},
    '{'{cgma_pkg::KIND_ACC,   8'd0,   5'd0,  VAL_MAX},             1'b0, '0},
    '{'{cgma_pkg::KIND_ACC,   8'd0,   5'd0,  VAL_MAX},             1'b0, '0},
    '{'{cgma_pkg::KIND_QUERY, 8'd0,   5'd0,  VAL_ZERO},            1'b1, MAX_OF_TWO},
    '{'{cgma_pkg::KIND_ACC,   8'd255, 5'd16, VAL_MIN},             1'b0, '0},
    '{'{cgma_pkg::KIND_QUERY, 8'd255, 5'd16, VAL_ZERO},            1'b1, MIN_OF_ONE},
    '{'{cgma_pkg::KIND_ACC,   8'd255, 5'd16, -48'sd1},             1'b0, '0},
    '{'{cgma_pkg::KIND_QUERY, 8'd255, 5'd16, VAL_ZERO},            1'b0, '0},
    '{'{cgma_pkg::KIND_ACC,   8'd7,   5'd5,  -48'sd3},             1'b0, '0},
    '{'{cgma_pkg::KIND_ACC,   8'd7,   5'd5,  48'sd1},              1'b0, '0},
    '{'{cgma_pkg::KIND_ACC,   8'd7,   5'd5,  VAL_ZERO},            1'b0, '0},
    '{'{cgma_pkg::KIND_QUERY, 8'd7,   5'd5,  VAL_ZERO},            1'b0, '0},
    '{'{cgma_pkg::KIND_ACC,   8'd9,   5'd31, 48'sd5},              1'b0, '0},
    '{'{cgma_pkg::KIND_QUERY, 8'd9,   5'd31, VAL_ZERO},            1'b1, EMPTY_RES},
    '{'{KIND_RSVD,            8'd0,   5'd0,  48'sd123},            1'b0, '0},
    '{'{cgma_pkg::KIND_QUERY, 8'd0,   5'd0,  VAL_ZERO},            1'b1, MAX_OF_TWO},
    '{'{cgma_pkg::KIND_CLEAR, 8'd0,   5'd0,  VAL_ZERO},            1'b0, '0},
    '{'{cgma_pkg::KIND_QUERY, 8'd0,   5'd0,  VAL_ZERO},            1'b1, EMPTY_RES},
    '{'{cgma_pkg::KIND_QUERY, 8'd255, 5'd16, VAL_ZERO},            1'b1, EMPTY_RES},
    '{'{cgma_pkg::KIND_ACC,   8'd128, 5'd16, 48'sh5555_5555_5555}, 1'b0, '0},
    '{'{cgma_pkg::KIND_ACC,   8'd128, 5'd16, 48'shAAAA_AAAA_AAAA}, 1'b0, '0},
    '{'{cgma_pkg::KIND_QUERY, 8'd128, 5'd16, VAL_ZERO},            1'b0, '0},
    '{'{cgma_pkg::KIND_QUERY, 8'd31,  5'd31, VAL_ZERO},            1'b1, EMPTY_RES}
  };

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [KIND_W-1:0]           kind_i;
  logic [CLASS_W-1:0]          class_id_i;
  logic [FIELD_W-1:0]          field_index_i;
  logic signed [VALUE_W-1:0]   value_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [MEAN_W-1:0]    mean_value_o;
  logic [MCOUNT_W-1:0]         member_count_o;
  logic                        is_empty_o;
  logic                        saturated_o;

  // Cell store as the bench sees it
  logic signed [SUM_W-1:0]     sum_of     [CELLS];
  logic [COUNT_BITS-1:0]       members_of [CELLS];
  logic                        dropped_of [CELLS];

  mean_res_t                   pending_means [$];
  int                          fail_count  = 0;
  int                          cycle_count = 0;
  bit                          idle_enable  = 1'b1;
  bit                          stall_enable = 1'b1;

  class_grouped_mean_accumulator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .class_id_i     (class_id_i),
    .field_index_i  (field_index_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mean_value_o   (mean_value_o),
    .member_count_o (member_count_o),
    .is_empty_o     (is_empty_o),
    .saturated_o    (saturated_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void zero_all_cells();
    for (int c = 0; c < CELLS; c++) begin
      sum_of[c]     = '0;
      members_of[c] = '0;
      dropped_of[c] = 1'b0;
    end
  endfunction

  // Update the store for one item; return the mean a query reports.
  function automatic void apply_to_cells(input cell_req_t r, output logic has_res,
                                         output mean_res_t res);
    logic                    in_rng;
    int                      idx;
    logic signed [SUM_W-1:0] quot;
    has_res = 1'b0;
    res     = '0;
    in_rng  = (int'(r.cls) < MAX_CLASSES) && (int'(r.fld) < FIELDS_PER_ITEM);
    idx     = int'(r.cls) * FIELDS_PER_ITEM + int'(r.fld);
    case (r.kind)
      cgma_pkg::KIND_ACC: begin
        if (in_rng) begin
          if (members_of[idx] == COUNT_MAX) begin
            dropped_of[idx] = 1'b1;
          end else begin
            sum_of[idx]     = sum_of[idx] + $signed(r.val);
            members_of[idx] = members_of[idx] + 1'b1;
          end
        end
      end
      cgma_pkg::KIND_QUERY: begin
        has_res = 1'b1;
        if (!in_rng || members_of[idx] == '0) begin
          res.empty = 1'b1;
        end else begin
          // signed divide truncates toward zero
          quot      = sum_of[idx] / $signed({{(SUM_W-COUNT_BITS){1'b0}}, members_of[idx]});
          res.mean  = quot[MEAN_W-1:0];
          res.count = members_of[idx];
        end
        res.sat = in_rng ? dropped_of[idx] : 1'b0;
      end
      cgma_pkg::KIND_CLEAR: zero_all_cells();
      default: ;
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] draw_value();
    logic [63:0] wide;
    int          near;
    wide = {$urandom(), $urandom()};
    near = int'($urandom_range(0, 200)) - 100;
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return VALUE_W'(near);
      default: return wide[VALUE_W-1:0];
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input cell_req_t r, input logic typed, input mean_res_t want);
    logic      has_res;
    mean_res_t res;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= r.kind;
    class_id_i    <= r.cls;
    field_index_i <= r.fld;
    value_i       <= r.val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_to_cells(r, has_res, res);
    if (has_res) pending_means = {pending_means, (typed ? want : res)};
    @(negedge clk_i);
  endtask

  // Receiver back-pressure in bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_enable && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    mean_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_means.size() == 0) begin
        $error("result with no query waiting: mean_value %0d", mean_value_o);
        fail_count++;
      end else begin
        want = pending_means.pop_front();
        if (mean_value_o !== want.mean) begin
          $error("mean_value: expected %0d, got %0d", want.mean, mean_value_o);
          fail_count++;
        end
        if (member_count_o !== want.count) begin
          $error("member_count: expected %0d, got %0d", want.count, member_count_o);
          fail_count++;
        end
        if (is_empty_o !== want.empty) begin
          $error("is_empty: expected %0b, got %0b", want.empty, is_empty_o);
          fail_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cell_req_t         r;
    mean_res_t         full_res;
    logic [CLASS_W-1:0] hot_cls [HOT_CELLS];
    logic [FIELD_W-1:0] hot_fld [HOT_CELLS];
    int                pick;
    int                h;
    int                clears_left;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = cgma_pkg::KIND_ACC;
    class_id_i    = '0;
    field_index_i = '0;
    value_i       = '0;
    zero_all_cells();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_STEPS[i]) send_item(DIR_STEPS[i].req, DIR_STEPS[i].typed, DIR_STEPS[i].want);

    // Fill one cell to a full count of maximum values, then push one add past it
    r = '{cgma_pkg::KIND_ACC, 8'd200, 5'd3, VAL_MAX};
    for (int n = 0; n < int'(COUNT_MAX); n++) send_item(r, 1'b0, '0);
    full_res = '{mean: VAL_MAX, count: COUNT_MAX, empty: 1'b0, sat: 1'b0};
    send_item('{cgma_pkg::KIND_QUERY, 8'd200, 5'd3, VAL_ZERO}, 1'b1, full_res);
    send_item(r, 1'b0, '0);
    full_res.sat = 1'b1;
    send_item('{cgma_pkg::KIND_QUERY, 8'd200, 5'd3, VAL_ZERO}, 1'b1, full_res);

    // Same with minimum values, the most negative sum a full cell can reach
    r = '{cgma_pkg::KIND_ACC, 8'd201, 5'd16, VAL_MIN};
    for (int n = 0; n <= int'(COUNT_MAX); n++) send_item(r, 1'b0, '0);
    full_res.mean = VAL_MIN;
    send_item('{cgma_pkg::KIND_QUERY, 8'd201, 5'd16, VAL_ZERO}, 1'b1, full_res);

    // A clear drops the overflow flag as well
    send_item('{cgma_pkg::KIND_CLEAR, 8'd0, 5'd0, VAL_ZERO}, 1'b0, '0);
    send_item('{cgma_pkg::KIND_QUERY, 8'd200, 5'd3, VAL_ZERO}, 1'b1, EMPTY_RES);

    for (int i = 0; i < HOT_CELLS; i++) begin
      hot_cls[i] = CLASS_W'($urandom_range(0, MAX_CLASSES - 1));
      hot_fld[i] = FIELD_W'($urandom_range(0, FIELDS_PER_ITEM - 1));
    end
    clears_left = 20;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        idle_enable  = ((n / 100) % 3) != 2;
        stall_enable = ((n / 100) % 4) != 1;
      end
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
        idle_enable  = 1'b0;
        stall_enable = 1'b0;
      end
      // Most items hit a few busy cells so queries see non-empty sums
      h     = $urandom_range(0, HOT_CELLS - 1);
      r.cls = hot_cls[h];
      r.fld = hot_fld[h];
      if ($urandom_range(0, 5) == 0) begin
        r.cls = CLASS_W'($urandom_range(0, MAX_CLASSES - 1));
        r.fld = FIELD_W'($urandom_range(0, 31));
      end
      r.val = draw_value();
      pick  = $urandom_range(0, 99);
      if (pick < 55) begin
        r.kind = cgma_pkg::KIND_ACC;
      end else if (pick < 94) begin
        r.kind = cgma_pkg::KIND_QUERY;
      end else if (pick < 99 || clears_left == 0) begin
        r.kind = KIND_RSVD;
      end else begin
        r.kind = cgma_pkg::KIND_CLEAR;
        clears_left--;
      end
      send_item(r, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cgma_pkg.sv
rtl/cgma_alu.sv
rtl/cgma_ram.sv
rtl/class_grouped_mean_accumulator.sv
tb/sv/class_grouped_mean_accumulator_tb.sv
